@@ hw/rtl/brl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brl_pkg
// Shared codes and types for the line rasterizer.
// ----------------------------------------------------------------------------
package brl_pkg;

   // Action codes carried on the request channel.
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Unit step along one axis: -1, 0 or +1 in two's complement.
   typedef logic signed [1:0] step_type;

   localparam step_type STEP_NEG  = 2'sb11;
   localparam step_type STEP_ZERO = 2'sb00;
   localparam step_type STEP_POS  = 2'sb01;

   // Step pair for one octant move.
   typedef struct packed {
      step_type x;
      step_type y;
   } step_pair_type;

endpackage : brl_pkg
`default_nettype wire

@@ hw/rtl/bresenham_line_rasterizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// All-octant Bresenham line walker: a load beat sets up a line, each tick
// beat on an active line plots the next pixel of it.
// ----------------------------------------------------------------------------
//
//  channel | prefix | dir | carries
//  --------+--------+-----+---------------------------------------------------
//  request | req_   | in  | action, both endpoints, line color
//  result  | rsp_   | out | pixel x/y, pixel color, last-pixel flag
//
//  One request beat is taken every cycle while req_ready is high; the whole
//  step (line setup or one error-term update) sits between the request ports
//  and the line state and result registers; a tick's pixel reaches rsp_ next cycle.
//  A tick while idle and every load beat produce no result beat.
//  req_ready drops only while a result beat is held and rsp_ready is low;
//  the result register parts the two sides.
//  Synchronous active-high reset leaves the block idle with no result held.
//
module bresenham_line_rasterizer #(
   parameter int COORD_BITS = 12,
   parameter int COLOR_BITS = 4
) (
   input  wire                          clock,
   input  wire                          reset,

   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_action,
   input  wire signed [COORD_BITS-1:0]  req_x_start,
   input  wire signed [COORD_BITS-1:0]  req_y_start,
   input  wire signed [COORD_BITS-1:0]  req_x_end,
   input  wire signed [COORD_BITS-1:0]  req_y_end,
   input  wire        [COLOR_BITS-1:0]  req_line_color,

   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic        [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                         rsp_last_pixel
);

   // Deltas and the error term need one bit above the coordinate width.
   localparam int WideBits = COORD_BITS + 1;

   // ---------------------------------------------------------------------
   // Line state
   // ---------------------------------------------------------------------
   logic [COORD_BITS-1:0]       cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]       cur_y_ff, cur_y_in;
   brl_pkg::step_pair_type      diag_ff, diag_in;
   brl_pkg::step_pair_type      straight_ff, straight_in;
   logic [COORD_BITS-1:0]       major_ff, major_in;
   logic [COORD_BITS-1:0]       minor_ff, minor_in;
   logic [WideBits-1:0]         error_ff, error_in;
   logic [WideBits-1:0]         left_ff, left_in;
   logic                        active_ff, active_in;
   logic [COLOR_BITS-1:0]       color_ff, color_in;

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]       rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]       rsp_y_ff, rsp_y_in;
   logic [COLOR_BITS-1:0]       rsp_color_ff, rsp_color_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic req_fire;
   logic load_fire;
   logic tick_emit;

   // ---------------------------------------------------------------------
   // Load setup: deltas, magnitudes, signs, axis choice
   // ---------------------------------------------------------------------
   logic signed [WideBits-1:0]  dx_s;
   logic signed [WideBits-1:0]  dy_s;
   logic [WideBits-1:0]         dx_abs;
   logic [WideBits-1:0]         dy_abs;
   logic [COORD_BITS-1:0]       aw;
   logic [COORD_BITS-1:0]       ah;
   brl_pkg::step_type           sx;
   brl_pkg::step_type           sy;
   logic                        x_major;

   // Tick: error update and step choice
   logic [WideBits-1:0]         err_sum;
   logic                        take_diag;
   brl_pkg::step_pair_type      step_sel;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_action == brl_pkg::ACTION_LOAD);
   assign tick_emit = req_fire && (req_action == brl_pkg::ACTION_TICK) && active_ff;

   always_comb begin
      dx_s = $signed({req_x_end[COORD_BITS-1], req_x_end})
           - $signed({req_x_start[COORD_BITS-1], req_x_start});
      dy_s = $signed({req_y_end[COORD_BITS-1], req_y_end})
           - $signed({req_y_start[COORD_BITS-1], req_y_start});
      dx_abs = dx_s[WideBits-1] ? WideBits'(-dx_s) : WideBits'(dx_s);
      dy_abs = dy_s[WideBits-1] ? WideBits'(-dy_s) : WideBits'(dy_s);
      // Magnitude never exceeds 2^COORD_BITS - 1.
      aw = dx_abs[COORD_BITS-1:0];
      ah = dy_abs[COORD_BITS-1:0];

      if (dx_s[WideBits-1]) begin
         sx = brl_pkg::STEP_NEG;
      end else if (dx_s != '0) begin
         sx = brl_pkg::STEP_POS;
      end else begin
         sx = brl_pkg::STEP_ZERO;
      end
      if (dy_s[WideBits-1]) begin
         sy = brl_pkg::STEP_NEG;
      end else if (dy_s != '0) begin
         sy = brl_pkg::STEP_POS;
      end else begin
         sy = brl_pkg::STEP_ZERO;
      end

      // Ties go to the y axis: every step is then diagonal.
      x_major = aw > ah;
   end

   always_comb begin
      err_sum   = error_ff + {1'b0, minor_ff};
      take_diag = err_sum >= {1'b0, major_ff};
      step_sel  = take_diag ? diag_ff : straight_ff;
   end

   // ---------------------------------------------------------------------
   // Next-state
   // ---------------------------------------------------------------------
   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      diag_in      = diag_ff;
      straight_in  = straight_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      error_in     = error_ff;
      left_in      = left_ff;
      active_in    = active_ff;
      color_in     = color_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;

      if (load_fire) begin
         // Start a new line, dropping any line in progress.
         cur_x_in   = req_x_start;
         cur_y_in   = req_y_start;
         diag_in.x  = sx;
         diag_in.y  = sy;
         if (x_major) begin
            major_in      = aw;
            minor_in      = ah;
            straight_in.x = sx;
            straight_in.y = brl_pkg::STEP_ZERO;
         end else begin
            major_in      = ah;
            minor_in      = aw;
            straight_in.x = brl_pkg::STEP_ZERO;
            straight_in.y = sy;
         end
         error_in  = {2'b00, major_in[COORD_BITS-1:1]};
         left_in   = {1'b0, major_in} + WideBits'(1);
         color_in  = req_line_color;
         active_in = 1'b1;
      end else if (tick_emit) begin
         // Plot the current pixel, then advance one octant step.
         rsp_valid_in = 1'b1;
         rsp_x_in     = cur_x_ff;
         rsp_y_in     = cur_y_ff;
         rsp_color_in = color_ff;
         rsp_last_in  = left_ff == WideBits'(1);

         error_in  = take_diag ? err_sum - {1'b0, major_ff} : err_sum;
         cur_x_in  = cur_x_ff + {{(COORD_BITS-2){step_sel.x[1]}}, step_sel.x};
         cur_y_in  = cur_y_ff + {{(COORD_BITS-2){step_sel.y[1]}}, step_sel.y};
         left_in   = left_ff - WideBits'(1);
         active_in = left_ff != WideBits'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         diag_ff      <= '0;
         straight_ff  <= '0;
         major_ff     <= '0;
         minor_ff     <= '0;
         error_ff     <= '0;
         left_ff      <= '0;
         active_ff    <= 1'b0;
         color_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         diag_ff      <= diag_in;
         straight_ff  <= straight_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         error_ff     <= error_in;
         left_ff      <= left_in;
         active_ff    <= active_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: no reset needed, qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // A new result beat only follows a tick taken on an active line.
   a_rsp_from_tick : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(tick_emit))
      else $error("result beat without an active tick");

   // An active line always has pixels left to plot.
   a_active_count : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (left_ff != '0))
      else $error("active line with zero pixels left");

   // The error term stays below a non-zero major length between ticks.
   a_error_bound : assert property (@(posedge clock) disable iff (reset)
      (active_ff && (major_ff != '0)) |-> (error_ff < {1'b0, major_ff}))
      else $error("error term out of range");

   // Plotting the final pixel ends the line.
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (tick_emit && (left_ff == WideBits'(1))) |=> !active_ff)
      else $error("line still active after its last pixel");

endmodule : bresenham_line_rasterizer
`default_nettype wire
